FILE: rtl/bipe_pkg.sv
// Shared types and constants for the bit-interleaved PCM packet encoder.
// No dependencies.
`default_nettype none
package bipe_pkg;

	localparam int FRAMES_PER_PACKET = 10;
	localparam int AUDIO_WORDS       = 12;
	localparam int TRAILER_WORDS     = 8;
	localparam int RUN_WORDS         = AUDIO_WORDS + TRAILER_WORDS;
	localparam int CNT_W             = $clog2(RUN_WORDS);
	localparam int FRAME_W           = 4;
	localparam int QUEUE_DEPTH       = 2;
	localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW          = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] MIDI_IDLE = 8'hFD;
	localparam logic [7:0] SYNC_BYTE = 8'hFF;

	// one classified frame, as queued between front and back
	typedef struct packed {
		logic [47:0] lo_bits;   // {ch1, ch2}
		logic [47:0] hi_bits;   // {ch3, ch4}
		logic        closing;
		logic [7:0]  midi_sel;
	} job_t;

endpackage
`default_nettype wire

FILE: rtl/bipe_front.sv
// Front end: accepts frames, tracks the frame count and classifies each frame.
// Depends on bipe_pkg.
`default_nettype none
module bipe_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [23:0]   ch1_sample,
	input  wire logic [23:0]   ch2_sample,
	input  wire logic [23:0]   ch3_sample,
	input  wire logic [23:0]   ch4_sample,
	input  wire logic          midi_present,
	input  wire logic [7:0]    midi_byte,
	input  wire logic          q_full,
	output logic               q_push,
	output bipe_pkg::job_t     q_job
);

	logic [bipe_pkg::FRAME_W-1:0] frame_index_q;
	logic                         closing;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign closing  = frame_index_q >= bipe_pkg::FRAME_W'(bipe_pkg::FRAMES_PER_PACKET - 1);

	always_comb begin
		q_job.lo_bits  = {ch1_sample, ch2_sample};
		q_job.hi_bits  = {ch3_sample, ch4_sample};
		q_job.closing  = closing;
		q_job.midi_sel = midi_present ? midi_byte : bipe_pkg::MIDI_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_index_q <= '0;
		end else if (q_push) begin
			if (closing) begin
				frame_index_q <= '0;
			end else begin
				frame_index_q <= frame_index_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bipe_queue.sv
// Short job queue between front and back end.
// Depends on bipe_pkg.
`default_nettype none
module bipe_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  bipe_pkg::job_t      push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output bipe_pkg::job_t      head_job
);

	bipe_pkg::job_t                 mem_q [bipe_pkg::QUEUE_DEPTH];
	logic [bipe_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [bipe_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [bipe_pkg::QUEUE_CW-1:0]  count_q;

	assign full      = count_q == bipe_pkg::QUEUE_CW'(bipe_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bipe_pkg::QUEUE_AW'(bipe_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bipe_pkg::QUEUE_AW'(bipe_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bipe_back.sv
// Back end: serializes one job into audio words, plus trailer words for a closing job, one per cycle while not stalled.
// Depends on bipe_pkg.
`default_nettype none
module bipe_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_not_empty,
	input  bipe_pkg::job_t     q_job,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [31:0]        data_word,
	output logic               last_of_run,
	output logic               packet_end
);

	logic [47:0]                lo_q;
	logic [47:0]                hi_q;
	logic                       closing_q;
	logic [7:0]                 midi_q;
	logic [bipe_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       out_valid_q;
	logic [31:0]                word_q;
	logic                       last_q;
	logic                       pend_q;

	logic        adv;
	logic        in_audio;
	logic        final_word;
	logic [31:0] audio_word;
	logic [31:0] trailer_word;

	assign adv        = !out_valid_q || !out_stall;
	assign in_audio   = cnt_q < bipe_pkg::CNT_W'(bipe_pkg::AUDIO_WORDS);
	assign final_word = closing_q ? (cnt_q == bipe_pkg::CNT_W'(bipe_pkg::RUN_WORDS - 1))
	                              : (cnt_q == bipe_pkg::CNT_W'(bipe_pkg::AUDIO_WORDS - 1));
	assign q_pop      = adv && (!busy_q || final_word) && q_not_empty;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			audio_word[8*k +: 8] = {6'b0, hi_q[47-k], lo_q[47-k]};
		end
		trailer_word = (cnt_q == bipe_pkg::CNT_W'(bipe_pkg::AUDIO_WORDS)) ?
			{16'h0000, bipe_pkg::SYNC_BYTE, midi_q} : 32'h0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			lo_q      <= q_job.lo_bits;
			hi_q      <= q_job.hi_bits;
			closing_q <= q_job.closing;
			midi_q    <= q_job.midi_sel;
		end else if (adv && busy_q && in_audio) begin
			lo_q <= {lo_q[43:0], 4'b0};
			hi_q <= {hi_q[43:0], 4'b0};
		end
		if (adv && busy_q) begin
			word_q <= in_audio ? audio_word : trailer_word;
			last_q <= final_word;
			pend_q <= final_word && closing_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= busy_q;
			if (q_pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (final_word) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign data_word   = word_q;
	assign last_of_run = last_q;
	assign packet_end  = pend_q;

endmodule
`default_nettype wire

FILE: rtl/bit_interleaved_pcm_packet_encoder_core.sv
// Top level of the bit-interleaved PCM packet encoder.
// Depends on bipe_pkg, bipe_front, bipe_queue and bipe_back.
//
// Each accepted frame of four 24-bit samples leaves as twelve 32-bit words of
// bit-interleaved bytes, little-endian, MSB first; every tenth frame is followed
// by eight trailer words (MIDI or idle byte, sync byte, zeros). The output word
// serializer emits one word per cycle while out_stall is low, and successive
// queued frames run without a gap. A two-entry frame queue lets new frames be
// taken while earlier words drain, and the output register holds a stalled word
// steady.
`default_nettype none
module bit_interleaved_pcm_packet_encoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [23:0] ch1_sample,
	input  wire logic [23:0] ch2_sample,
	input  wire logic [23:0] ch3_sample,
	input  wire logic [23:0] ch4_sample,
	input  wire logic        midi_present,
	input  wire logic [7:0]  midi_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      data_word,
	output logic             last_of_run,
	output logic             packet_end
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_not_empty;
	bipe_pkg::job_t push_job;
	bipe_pkg::job_t head_job;

	bipe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ch1_sample   (ch1_sample),
		.ch2_sample   (ch2_sample),
		.ch3_sample   (ch3_sample),
		.ch4_sample   (ch4_sample),
		.midi_present (midi_present),
		.midi_byte    (midi_byte),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (push_job)
	);

	bipe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_job  (head_job)
	);

	bipe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_job       (head_job),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_word   (data_word),
		.last_of_run (last_of_run),
		.packet_end  (packet_end)
	);

	a_pend_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_end |-> last_of_run)
		else $error("packet_end without last_of_run");

	a_pend_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_end |-> data_word == 32'h0)
		else $error("final trailer word not zero");

	a_audio_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run && !packet_end |-> (data_word & 32'hFCFC_FCFC) == 32'h0)
		else $error("audio word carries bits above lane bits");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("push into full queue");

endmodule
`default_nettype wire
